// ----- sv/pfu_pkg.sv -----
// Package of shared types, constants and helpers for the packed field unpacker.
package pfu_pkg;

   localparam int WORD_BITS      = 64;
   localparam int MAX_ENTRY_BITS = 8;
   localparam int WIDTH_BITS     = 4;
   localparam int LEFT_BITS      = $clog2(WORD_BITS + 1);

   typedef logic [WIDTH_BITS-1:0]     width_type;
   typedef logic [MAX_ENTRY_BITS-1:0] entry_type;
   typedef logic [WORD_BITS-1:0]      word_type;
   typedef logic [LEFT_BITS-1:0]      left_type;
   typedef logic [2:0]                miss_type;

   localparam width_type WIDTH_RESET = width_type'(4);

   // One step of the sequencer as seen by the output stage.
   typedef struct packed {
      logic      valid;
      entry_type entry;
      logic      last;
   } step_type;

   // Map a raw width code to the usable range 1..MAX_ENTRY_BITS.
   function automatic width_type eff_width(input width_type raw);
      width_type w;
      w = raw;
      if (w == width_type'(0)) begin
         w = width_type'(1);
      end else if (w > width_type'(MAX_ENTRY_BITS)) begin
         w = width_type'(MAX_ENTRY_BITS);
      end
      return w;
   endfunction

   // Ones in the n low bits of an entry.
   function automatic entry_type low_mask(input width_type n);
      logic [MAX_ENTRY_BITS:0] m;
      m = '0;
      if (n >= width_type'(MAX_ENTRY_BITS)) begin
         m = {1'b0, {MAX_ENTRY_BITS{1'b1}}};
      end else begin
         m = ((MAX_ENTRY_BITS+1)'(1) << n) - (MAX_ENTRY_BITS+1)'(1);
      end
      return m[MAX_ENTRY_BITS-1:0];
   endfunction

endpackage

// ----- sv/pfu_extract.sv -----
// Shared shift-and-mask unit: takes one entry off the low end of the word.
module pfu_extract (
   input  pfu_pkg::word_type  word,
   input  pfu_pkg::entry_type pend,
   input  logic               carry,
   input  pfu_pkg::miss_type  miss,
   input  pfu_pkg::width_type width,
   output pfu_pkg::entry_type entry,
   output pfu_pkg::word_type  shifted
);
   import pfu_pkg::*;

   width_type                 take;
   width_type                 base;
   entry_type                 hi;
   logic [2*MAX_ENTRY_BITS-1:0] placed;
   entry_type                 low_part;

   always_comb begin
      take     = carry ? {1'b0, miss} : width;
      base     = carry ? width - {1'b0, miss} : width_type'(0);
      hi       = word[MAX_ENTRY_BITS-1:0] & low_mask(take);
      placed   = {{MAX_ENTRY_BITS{1'b0}}, hi} << base;
      low_part = carry ? pend : entry_type'(0);
      entry    = (low_part | placed[MAX_ENTRY_BITS-1:0]) & low_mask(width);
      shifted  = word >> take;
   end

endmodule

// ----- sv/pfu_seq.sv -----
// Sequencer: holds the word and the carry, and steps the shared extractor once per entry.
module pfu_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  pfu_pkg::width_type width,
   input  logic               load,
   input  pfu_pkg::word_type  load_word,
   input  logic               load_last,
   input  logic               go,
   output logic               idle,
   output pfu_pkg::step_type  step
);
   import pfu_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type state_ff, state_in;
   word_type  word_ff, word_in;
   left_type  left_ff, left_in;
   logic      last_ff, last_in;
   logic      first_ff, first_in;
   entry_type pend_ff, pend_in;
   miss_type  miss_ff, miss_in;

   logic      carry;
   logic      partial;
   width_type take;
   left_type  left_next;
   logic      done;
   entry_type entry;
   word_type  shifted;

   pfu_extract u_extract (
      .word    (word_ff),
      .pend    (pend_ff),
      .carry   (carry),
      .miss    (miss_ff),
      .width   (width),
      .entry   (entry),
      .shifted (shifted)
   );

   always_comb begin
      carry     = first_ff && (miss_ff != miss_type'(0)) && ({1'b0, miss_ff} < width);
      partial   = !carry && (left_ff < left_type'(width));
      take      = carry ? {1'b0, miss_ff} : width;
      left_next = partial ? left_type'(0) : left_ff - left_type'(take);
      done      = partial || (left_next == left_type'(0))
                  || (!last_ff && (left_next < left_type'(width)));

      idle       = (state_ff == ST_IDLE);
      step.valid = (state_ff == ST_RUN);
      step.entry = entry;
      step.last  = done;

      state_in = state_ff;
      word_in  = word_ff;
      left_in  = left_ff;
      last_in  = last_ff;
      first_in = first_ff;
      pend_in  = pend_ff;
      miss_in  = miss_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               word_in  = load_word;
               left_in  = left_type'(WORD_BITS);
               last_in  = load_last;
               first_in = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (go) begin
               word_in  = shifted;
               left_in  = left_next;
               first_in = 1'b0;
               if (done) begin
                  state_in = ST_IDLE;
                  if (!partial && left_next != left_type'(0) && !last_ff) begin
                     // Park the straddling low bits until the next word.
                     pend_in = shifted[MAX_ENTRY_BITS-1:0] & low_mask(width);
                     miss_in = miss_type'(width - width_type'(left_next));
                  end else begin
                     pend_in = '0;
                     miss_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (clear) begin
         pend_in = '0;
         miss_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
         pend_ff  <= '0;
         miss_ff  <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         pend_ff  <= pend_in;
         miss_ff  <= miss_in;
      end
      word_ff <= word_in;
      left_ff <= left_in;
      last_ff <= last_in;
   end

endmodule

// ----- sv/packed_field_unpacker.sv -----
// Top level of the packed field unpacker: config register, sequencer and output register.
// Splits each 64-bit word of a densely packed array into entries of entry_width bits
// (1 to 8; 0 reads as 1, 9..15 as 8), lowest bits first, one entry per beat on rsp_.
// An entry that straddles two words is finished from the low bits of the next word;
// on a word with req_tlast set a trailing partial entry goes out with only the bits it
// has and the carry drops. rsp_tlast marks the final entry of each word. A word is
// accepted while the sequencer is idle, then the single shared shift-and-mask unit
// peels one entry a cycle, holding whenever the output register is full and not
// being drained. req_tready is low while a word is being split; the next word is
// taken while the final entry still waits in the output register.
// Writing entry_width clears any carry; write it only while the block is idle.
module packed_field_unpacker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  pfu_pkg::width_type        csr_wdata,   // entry_width
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  pfu_pkg::word_type         req_tdata,   // [63:0] packed_word
   input  logic                      req_tlast,   // last_word
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output pfu_pkg::entry_type        rsp_tdata,   // [7:0] entry
   output logic                      rsp_tlast    // last_of_word
);
   import pfu_pkg::*;

   width_type width_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   entry_type rsp_data_ff, rsp_data_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      out_free;
   logic      seq_idle;
   logic      req_beat;
   step_type  step;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_beat = req_tvalid && req_tready;

   // Hold the saturated width so the datapath never sees an out-of-range code.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_wen) begin
         width_ff <= eff_width(csr_wdata);
      end
   end

   pfu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_wen),
      .width     (width_ff),
      .load      (req_beat),
      .load_word (req_tdata),
      .load_last (req_tlast),
      .go        (out_free),
      .idle      (seq_idle),
      .step      (step)
   );

   assign req_tready = seq_idle;

   // Advance the output register whenever the slot is empty or being drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = step.valid;
         rsp_data_in  = step.entry;
         rsp_last_in  = step.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A word beat always starts a run, so the input side closes right after.
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("req_tready high right after a word beat");

   // The width register only ever holds a usable width.
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= width_type'(1)) && (width_ff <= width_type'(MAX_ENTRY_BITS)))
      else $error("entry width out of range");

   // The final entry of a word, once taken, returns the sequencer to idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (step.valid && out_free && step.last) |=> req_tready)
      else $error("sequencer still busy after the final entry of a word");

   // An entry moves into the output only while the sequencer runs.
   a_step_only_busy: assert property (@(posedge clock) disable iff (reset)
      step.valid |-> !req_tready)
      else $error("step valid while sequencer idle");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the packed field unpacker: directed and random words checked beat by beat.
module tb;
   import pfu_pkg::*;

   localparam int TOTAL_WORDS    = 310;   // stop offering words after this many
   localparam int LONG_HOLD      = 300;   // cycles the receiver holds off once
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up
   localparam int DRAIN_CYCLES   = 80;    // cycles of extra wait after the final drain

   // One expected beat on the result channel.
   typedef struct packed {
      entry_type value;
      logic      mark;
   } due_entry_type;

   // Tracks the width and the straddling carry, predicts the entries of each
   // accepted word and checks the result beats against them in order.
   class unpack_tracker_type;
      width_type     width_code;
      entry_type     carry_value;
      miss_type      carry_missing;
      due_entry_type entries_due[$];
      int            words_seen;
      int            entries_checked;
      int            mismatches;
      int            widths_written;

      function new();
         width_code      = WIDTH_RESET;
         carry_value     = '0;
         carry_missing   = '0;
         words_seen      = 0;
         entries_checked = 0;
         mismatches      = 0;
         widths_written  = 0;
      endfunction

      // A width write drops any carry.
      function void set_width(width_type code);
         width_code    = code;
         carry_value   = '0;
         carry_missing = '0;
         widths_written++;
      endfunction

      function int usable_width();
         int w;
         w = int'(width_code);
         if (w == 0) w = 1;
         if (w > MAX_ENTRY_BITS) w = MAX_ENTRY_BITS;
         return w;
      endfunction

      function void push_entry(entry_type value);
         due_entry_type e;
         e.value = value;
         e.mark  = 1'b0;
         entries_due.push_back(e);
      endfunction

      function void note_word(word_type word, logic last);
         int            w;
         int            pos;
         int            have;
         entry_type     mask;
         entry_type     hi;
         entry_type     part;
         due_entry_type tail;
         w    = usable_width();
         mask = entry_type'((9'd1 << w) - 9'd1);
         pos  = 0;
         // Finish a straddling entry from the low bits of this word.
         if (carry_missing != '0 && int'(carry_missing) < w) begin
            hi   = word[7:0] & entry_type'((9'd1 << carry_missing) - 9'd1);
            have = w - int'(carry_missing);
            push_entry((carry_value | entry_type'(hi << have)) & mask);
            pos = int'(carry_missing);
         end
         while (pos + w <= WORD_BITS) begin
            push_entry(entry_type'(word >> pos) & mask);
            pos += w;
         end
         if (pos < WORD_BITS) begin
            part = entry_type'(word >> pos) & mask;
            if (last) begin
               push_entry(part);
               carry_value   = '0;
               carry_missing = '0;
            end else begin
               carry_value   = part;
               carry_missing = miss_type'(w - (WORD_BITS - pos));
            end
         end else begin
            carry_value   = '0;
            carry_missing = '0;
         end
         // Flag the final entry of this word.
         tail      = entries_due.pop_back();
         tail.mark = 1'b1;
         entries_due.push_back(tail);
         words_seen++;
      endfunction

      function void check_entry(entry_type value, logic mark);
         due_entry_type e;
         entries_checked++;
         if (entries_due.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected entry %02h last %0b", $realtime, value, mark);
            mismatches++;
         end else begin
            e = entries_due.pop_front();
            if (e.value !== value || e.mark !== mark) begin
               if (mismatches < 10)
                  $display("%0t: entry mismatch: expected %02h last %0b, got %02h last %0b",
                           $realtime, e.value, e.mark, value, mark);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wen;
   width_type  csr_wdata;
   logic       req_tvalid;
   logic       req_tready;
   word_type   req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   entry_type  rsp_tdata;
   logic       rsp_tlast;

   unpack_tracker_type tracker;
   bit  quiet;       // no idling on either side in the closing part
   bit  long_hold;   // asks the receiver for one long hold-off
   int  idle_cycles;

   packed_field_unpacker i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),   // entry_width
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [63:0] packed_word
      .req_tlast  (req_tlast),   // last_word
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] entry
      .rsp_tlast  (rsp_tlast)    // last_of_word
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Sample every beat at the rising edge. Width writes reset the carry in the
   // tracker just as they do in the block.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) tracker.set_width(csr_wdata);
         if (rsp_tvalid && rsp_tready) tracker.check_entry(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) tracker.note_word(req_tdata, req_tlast);
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", idle_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Receiver: random hold-off bursts, one long hold-off on request, and none
   // at all once the run goes quiet. At most one assignment per falling edge.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (hold = 1; hold < LONG_HOLD; hold++) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            // a stretch with the receiver always ready
            rsp_tready <= 1'b1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one word, optionally after a gap, and hold it until accepted.
   task automatic send_word(word_type word, logic last, int gap);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected entry has come out.
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (tracker.entries_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write entry_width; the block must be idle.
   task automatic write_width(width_type code);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= code;
      @(negedge clock) csr_wen <= 1'b0;
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 6);
      return 0;
   endfunction

   // Mostly random words, with all-zero and all-one words mixed in.
   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int        sent;
      int        phase;
      int        budget;
      int        run_len;
      int        k;
      bit        calm;
      bit        broken;
      logic      mark;
      width_type code;
      width_type forced_codes[4];

      tracker     = new();
      forced_codes = '{width_type'(1), width_type'(8), width_type'(2), width_type'(4)};
      reset       = 1'b1;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      quiet       = 1'b0;
      long_hold   = 1'b0;
      idle_cycles = 0;
      sent        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: reset width 4; the last word lands on an entry boundary.
      send_word(64'h0000_0000_0000_0000, 1'b0, 0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
      send_word(64'hA5A5_A5A5_5A5A_5A5A, 1'b1, 0);
      sent += 3;

      // Width 3: entries straddle words, and the last word ends on an entry boundary.
      settle();
      write_width(width_type'(3));
      send_word(64'h0123_4567_89AB_CDEF, 1'b0, 0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
      send_word(64'h8000_0000_0000_0001, 1'b1, 0);
      sent += 3;

      // Width code zero reads as one bit: 64 entries per word.
      settle();
      write_width(width_type'(0));
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0);
      send_word(64'h5555_5555_5555_5555, 1'b0, 0);
      sent += 2;

      // Codes above eight saturate to eight bits.
      settle();
      write_width(width_type'(15));
      send_word(64'hFEDC_BA98_7654_3210, 1'b1, 0);
      settle();
      write_width(width_type'(9));
      send_word(64'h0F0F_F0F0_3C3C_C3C3, 1'b0, 0);
      sent += 2;

      // Leave a carry pending at width 7, then change width: the carry must drop.
      settle();
      write_width(width_type'(7));
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0);
      settle();
      write_width(width_type'(5));
      send_word(64'hC3C3_C3C3_C3C3_C3C3, 1'b0, 0);
      send_word(64'h1234_5678_9ABC_DEF0, 1'b0, 0);
      send_word(64'h9E37_79B9_7F4A_7C15, 1'b1, 0);
      sent += 4;

      // Random phases: one width each, arrays of words ending in a last word,
      // with the odd array carrying random last flags.
      phase = 0;
      while (sent < TOTAL_WORDS) begin
         code = (phase < 4) ? forced_codes[phase] : width_type'($urandom_range(0, 15));
         settle();
         write_width(code);
         calm = ($urandom_range(0, 3) == 0);
         // Hold the receiver off while words keep coming, so the block backs up.
         if (phase == 2) long_hold = 1'b1;
         budget = $urandom_range(15, 35);
         while (budget > 0 && sent < TOTAL_WORDS) begin
            run_len = $urandom_range(1, 6);
            broken  = ($urandom_range(0, 7) == 0);
            for (k = 0; k < run_len; k++) begin
               if (sent >= TOTAL_WORDS - 40) quiet = 1'b1;
               mark = broken ? logic'($urandom_range(0, 1)) : logic'(k == run_len - 1);
               send_word(random_word(), mark, (quiet || calm) ? 0 : pick_gap());
               sent++;
               budget--;
            end
            // Now and then pause until every entry has drained.
            if (!quiet && $urandom_range(0, 9) == 0) settle();
         end
         phase++;
      end

      // Drain, then give a stray late entry the time to show up.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d words through %0d width writes; checked %0d entries",
               tracker.words_seen, tracker.widths_written, tracker.entries_checked);
      $display("Mismatches %0d, entries still owed %0d",
               tracker.mismatches, tracker.entries_due.size());
      if (tracker.mismatches == 0 && tracker.entries_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
